/* src/ltsc_pkg.sv */
// Shared types, codes and font tables for the LED text scroller.
package ltsc_pkg;

  localparam int unsigned FONT_GLYPHS  = 29;
  localparam int unsigned FONT_BYTES   = 133;
  localparam int unsigned BUF_COLS     = 9;
  localparam int unsigned COL_W        = 8;
  localparam int unsigned DISP_COLS    = 8;

  localparam logic [2:0] LAST_COL      = 3'd7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Controls from the sequencer to the column buffer.
  typedef struct packed {
    logic             shift;
    logic [COL_W-1:0] new_col;
    logic [2:0]       sel;
  } col_ctl_t;

  typedef struct packed {
    logic [7:0] start;
    logic [2:0] width;
  } glyph_t;

  localparam logic [7:0] GLYPH_CODES [FONT_GLYPHS] = '{
    8'h20, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73,
    8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h21, 8'h2E
  };

  localparam logic [2:0] GLYPH_WIDTHS [FONT_GLYPHS] = '{
    3'd2, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd4,
    3'd4, 3'd5, 3'd4, 3'd7, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd4, 3'd5, 3'd5, 3'd7, 3'd5, 3'd5, 3'd5, 3'd2, 3'd2
  };

  localparam logic [7:0] GLYPH_STARTS [FONT_GLYPHS] = '{
    8'd0,   8'd2,   8'd7,   8'd12,  8'd16,  8'd21,  8'd25,  8'd29,  8'd34,  8'd39,
    8'd43,  8'd47,  8'd52,  8'd56,  8'd63,  8'd68,  8'd73,  8'd78,  8'd83,  8'd88,
    8'd93,  8'd97,  8'd102, 8'd107, 8'd114, 8'd119, 8'd124, 8'd129, 8'd131
  };

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'h00, 8'h00,
    8'h3E, 8'h3F, 8'h09, 8'h3F, 8'h3E,
    8'h3F, 8'h3F, 8'h25, 8'h3F, 8'h1A,
    8'h1E, 8'h3F, 8'h21, 8'h21,
    8'h3F, 8'h3F, 8'h21, 8'h3F, 8'h1E,
    8'h3F, 8'h3F, 8'h25, 8'h21,
    8'h3F, 8'h3F, 8'h05, 8'h01,
    8'h1E, 8'h3F, 8'h21, 8'h3D, 8'h3C,
    8'h3F, 8'h3F, 8'h04, 8'h3F, 8'h3F,
    8'h21, 8'h3F, 8'h3F, 8'h21,
    8'h20, 8'h20, 8'h3F, 8'h1F,
    8'h3F, 8'h3F, 8'h04, 8'h3B, 8'h31,
    8'h3F, 8'h3F, 8'h20, 8'h20,
    8'h3F, 8'h3F, 8'h01, 8'h3F, 8'h01, 8'h3F, 8'h3E,
    8'h3F, 8'h3F, 8'h01, 8'h3F, 8'h3E,
    8'h1E, 8'h3F, 8'h21, 8'h3F, 8'h1E,
    8'h3F, 8'h3F, 8'h09, 8'h0F, 8'h06,
    8'h1E, 8'h3F, 8'h31, 8'h2F, 8'h5E,
    8'h3F, 8'h3F, 8'h09, 8'h3F, 8'h36,
    8'h32, 8'h37, 8'h25, 8'h3D, 8'h19,
    8'h01, 8'h3F, 8'h3F, 8'h01,
    8'h1F, 8'h3F, 8'h20, 8'h3F, 8'h1F,
    8'h07, 8'h1F, 8'h20, 8'h3F, 8'h3F,
    8'h1F, 8'h3F, 8'h20, 8'h3F, 8'h20, 8'h3F, 8'h1F,
    8'h31, 8'h3B, 8'h04, 8'h3B, 8'h31,
    8'h27, 8'h2F, 8'h28, 8'h3F, 8'h1F,
    8'h31, 8'h39, 8'h29, 8'h27, 8'h23,
    8'h2F, 8'h2F,
    8'h30, 8'h30
  };

  // Codes are distinct, so at most one compare hits; a miss maps to space.
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    g.start = GLYPH_STARTS[0];
    g.width = GLYPH_WIDTHS[0];
    for (int i = 0; i < FONT_GLYPHS; i++) begin
      if (code == GLYPH_CODES[i]) begin
        g.start = GLYPH_STARTS[i];
        g.width = GLYPH_WIDTHS[i];
      end
    end
    return g;
  endfunction

  function automatic logic [COL_W-1:0] font_column(input logic [7:0] pos);
    logic [COL_W-1:0] c;
    c = '0;
    if (pos < 8'(FONT_BYTES)) begin
      c = FONT_ROM[pos];
    end
    return c;
  endfunction

endpackage

/* src/ltsc_msg_ram.sv */
// Message text store: one write port, one registered read port.
module ltsc_msg_ram
  import ltsc_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ltsc_col_buf.sv */
// Nine-column shift buffer with lit/shadow column select.
module ltsc_col_buf
  import ltsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  col_ctl_t         ctl,
  output logic [COL_W-1:0] lit,
  output logic [COL_W-1:0] shade
);

  logic [COL_W-1:0] cols [BUF_COLS];
  logic [3:0]       idx_lit;
  logic [3:0]       idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUF_COLS; i++) begin
        cols[i] <= '0;
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < BUF_COLS - 1; i++) begin
        cols[i] <= cols[i+1];
      end
      cols[BUF_COLS-1] <= ctl.new_col;
    end
  end

  assign idx_lit  = {1'b0, ctl.sel};
  assign idx_next = {1'b0, ctl.sel} + 4'd1;
  assign lit      = cols[idx_lit];
  assign shade    = cols[idx_next] & ~cols[idx_lit];

endmodule

/* src/led_matrix_text_scroller_core.sv */
// Scrolling text for an 8x8 LED matrix: top level, sequencer and output register.
//
// A write item (op 0) stores one character. A tick item
// (op 1) shifts the column buffer, appends a font or gap column and then
// sends eight column items through a single output register, one per cycle
// while the consumer keeps ready high. The buffer shifts in the accept cycle,
// and no new item is taken until the last column has been loaded.
// When a tick appends the gap column ahead of a new glyph
// the message store is read in the cycle of acceptance and the font lookup
// finishes in the following cycle, hidden behind the column output.
// Characters outside the font show as a space. message_length of 0 acts as 1
// and values above MESSAGE_DEPTH act as MESSAGE_DEPTH.
module led_matrix_text_scroller_core
  import ltsc_pkg::*;
#(
  parameter int unsigned MESSAGE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [5:0] char_slot,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] column_number,
  output logic [7:0] lit_rows,
  output logic [7:0] shade_rows,
  output logic       final_column
);

  localparam int unsigned AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
  localparam int unsigned LW = (AW + 1 > 7) ? AW + 1 : 7;
  localparam logic [LW-1:0] DEPTH_L = LW'(MESSAGE_DEPTH);

  logic [6:0]       message_length;
  state_t           state, state_next;
  logic [2:0]       sel, sel_next;
  logic             in_glyph;
  logic [2:0]       columns_remaining;
  logic [7:0]       font_position;
  logic [AW-1:0]    message_position;
  logic             lookup_pending;

  logic             accept, tick, wr;
  logic             load;
  logic [LW-1:0]    len_eff;
  logic [AW-1:0]    pos_eff;
  logic [LW-1:0]    pos_inc;
  logic [2:0]       rem_dec;
  logic             need_char;
  logic [7:0]       rd_code;
  glyph_t           glyph;
  col_ctl_t         ctl;
  logic [COL_W-1:0] col_lit, col_shade;

  assign accept = in_valid && in_ready;
  assign tick   = accept && (op == OP_TICK);
  assign wr     = accept && (op == OP_WRITE) && (LW'(char_slot) < DEPTH_L);

  always_comb begin
    len_eff = LW'(message_length);
    if (len_eff == '0) begin
      len_eff = LW'(1);
    end
    if (len_eff > DEPTH_L) begin
      len_eff = DEPTH_L;
    end
  end

  // Restart at zero if the length shrank under the current position.
  assign pos_eff   = (LW'(message_position) >= len_eff) ? '0 : message_position;
  assign pos_inc   = LW'(pos_eff) + LW'(1);
  assign rem_dec   = columns_remaining - 3'd1;
  assign need_char = !in_glyph && (rem_dec == 3'd0);

  ltsc_msg_ram #(
    .DEPTH (MESSAGE_DEPTH),
    .AW    (AW)
  ) u_msg_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (AW'(char_slot)),
    .wdata (char_code),
    .re    (tick && need_char),
    .raddr (pos_eff),
    .rdata (rd_code)
  );

  assign glyph = glyph_lookup(rd_code);

  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= 7'd1;
    end else if (cfg_write) begin
      message_length <= cfg_data;
    end
  end

  // Glyph sequencing; the read of the next character resolves in the cycle after it is issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_glyph          <= 1'b0;
      columns_remaining <= 3'd1;
      font_position     <= '0;
      message_position  <= '0;
      lookup_pending    <= 1'b0;
    end else begin
      lookup_pending <= 1'b0;
      if (lookup_pending) begin
        font_position     <= glyph.start;
        columns_remaining <= glyph.width;
        in_glyph          <= 1'b1;
      end else if (tick) begin
        if (!in_glyph) begin
          columns_remaining <= rem_dec;
          if (need_char) begin
            lookup_pending   <= 1'b1;
            message_position <= (pos_inc >= len_eff) ? '0 : AW'(pos_inc);
          end
        end else begin
          font_position <= font_position + 8'd1;
          if (rem_dec == 3'd0) begin
            in_glyph          <= 1'b0;
            columns_remaining <= 3'd1;
          end else begin
            columns_remaining <= rem_dec;
          end
        end
      end
    end
  end

  assign ctl.shift   = tick;
  assign ctl.new_col = in_glyph ? font_column(font_position) : '0;
  assign ctl.sel     = sel;

  ltsc_col_buf u_col_buf (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .lit   (col_lit),
    .shade (col_shade)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    in_ready   = 1'b0;
    load       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (tick) begin
          state_next = ST_EMIT;
          sel_next   = '0;
        end
      end
      ST_EMIT: begin
        load = !out_valid || out_ready;
        if (load) begin
          sel_next = sel + 3'd1;
          if (sel == LAST_COL) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        sel_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      column_number <= sel;
      lit_rows      <= col_lit;
      shade_rows    <= col_shade;
      final_column  <= (sel == LAST_COL);
    end
  end

`ifndef ASSERT_OFF
  // A new tick must never arrive before the previous glyph lookup lands.
  a_lookup_hidden: assert property (@(posedge clk) disable iff (rst)
    lookup_pending |-> !in_ready)
    else $error("glyph lookup overlaps an accepted item");

  a_tick_starts_emit: assert property (@(posedge clk) disable iff (rst)
    tick |=> (state == ST_EMIT) && (sel == 3'd0))
    else $error("tick did not start column output at column zero");

  a_idle_sel_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (sel == 3'd0))
    else $error("column counter not rewound at end of frame");

  // The countdown sits at zero only while the glyph lookup is landing.
  a_remaining_nonzero: assert property (@(posedge clk) disable iff (rst)
    !lookup_pending |-> (columns_remaining != 3'd0))
    else $error("column countdown reached zero without reload");
`endif

endmodule
